// File: rtl/core/wtpc_pkg.sv
`default_nettype none

package wtpc_pkg;

	// Bus clock used when the configured value is zero.
	localparam logic [31:0] CLK_DEFAULT_HZ = 32'd64000000;

	// Divider widths: a count divides the timeout times 1000 by a tick length.
	localparam int DIVIDEND_W = 42;
	localparam int DIVISOR_W  = 39;
	localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

	// Tick base in microseconds for prescaler zero: 4096 * 1000000.
	localparam logic [DIVIDEND_W-1:0] TICK_BASE_US = DIVIDEND_W'(64'd4096000000);

	localparam logic [2:0] PRESCALER_LAST = 3'd7;
	localparam logic [6:0] RELOAD_BASE    = 7'h3F;
	localparam logic [6:0] RELOAD_MAX     = 7'h7F;
	localparam logic [DIVIDEND_W-1:0] MAX_TICKS = DIVIDEND_W'(64);

	// Status codes.
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_PARAM_ERR = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_TICK,
		ST_TICK_WAIT,
		ST_COUNT,
		ST_COUNT_WAIT,
		ST_FINISH
	} state_t;

	// Request to the shared divider.
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	// Answer from the shared divider.
	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
		logic [DIVISOR_W-1:0]  remainder;
	} div_rsp_t;

	// One result item.
	typedef struct packed {
		logic       status;
		logic [2:0] prescaler;
		logic [6:0] reload_count;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/watchdog_timeout_to_prescaler_count.sv
// Watchdog set-up calculator: turns a timeout in milliseconds into a prescaler
// exponent and a reload count for the configured bus clock.
// Input channel: timeout_valid, timeout_stall and period_ms. A transfer takes
// place when valid is high and stall is low; stall stays high while an item is
// being worked on, so one item is handled at a time.
// Output channel: result_valid, result_stall, status, prescaler, reload_count.
// The result sits in an output register and holds while result_stall is high;
// the next item is accepted meanwhile, but its result waits until the register
// is free.
// Configuration: cfg_valid, cfg_ready and bus_clock_hz write the clock register,
// which resets to 64 MHz; a value of zero is read as 64 MHz.
// Divider: one shared 42-step restoring divider does all the divisions. A
// prescaler trial takes two divisions, or one when its tick is zero, and a zero
// timeout needs no division. There are up to eight trials per item; the next
// input is taken once the result of the last one has moved into the output
// register.
// Reset clears the sequencer and the output valid flag; no result is pending.

`default_nettype none

module watchdog_timeout_to_prescaler_count
	import wtpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        timeout_valid,
	output logic             timeout_stall,
	input  wire logic [31:0] period_ms,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             status,
	output logic [2:0]       prescaler,
	output logic [6:0]       reload_count,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] bus_clock_hz
);

	logic [31:0] clk_hz_q;
	logic [31:0] clk_eff;
	logic        busy;
	logic        res_valid;
	logic        res_take;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	// Clock register, always ready for a transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_DEFAULT_HZ;
		end else if (cfg_valid) begin
			clk_hz_q <= bus_clock_hz;
		end
	end

	assign clk_eff = (clk_hz_q == '0) ? CLK_DEFAULT_HZ : clk_hz_q;

	assign timeout_stall = busy;

	wtpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (timeout_valid),
		.period_ms  (period_ms),
		.clk_hz     (clk_eff),
		.busy       (busy),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (res_take)
	);

	wtpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Output register: loads when empty or when its content leaves this cycle.
	assign res_take = res_valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_q.status;
	assign prescaler    = out_q.prescaler;
	assign reload_count = out_q.reload_count;

endmodule

`default_nettype wire

// File: rtl/core/wtpc_div.sv
`default_nettype none

module wtpc_div
	import wtpc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;

	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;
	logic [DIVISOR_W-1:0]  rem_next;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		shifted  = {rem_q, quo_q[DIVIDEND_W-1]};
		diff     = shifted - {1'b0, dvs_q};
		ge       = (shifted >= {1'b0, dvs_q});
		rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
	end

	// Step counter and completion flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= rem_next;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: rtl/core/wtpc_ctrl.sv
`default_nettype none

module wtpc_ctrl
	import wtpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic [31:0] period_ms,
	input  wire logic [31:0] clk_hz,
	output logic             busy,
	output div_req_t         div_req,
	input  wire div_rsp_t    div_rsp,
	output logic             res_valid,
	output result_t          res,
	input  wire logic        res_take
);

	state_t                state_q;
	state_t                state_d;
	logic [31:0]           timeout_q;
	logic [DIVIDEND_W-1:0] scaled_q;
	logic [DIVISOR_W-1:0]  tick_q;
	logic [2:0]            p_q;
	result_t               res_q;

	logic                  accept;
	logic                  tick_zero;
	logic                  rem_nz;
	logic                  fits;
	logic [6:0]            ticks;
	logic [DIVIDEND_W-1:0] scaled;
	logic                  last_p;

	assign accept = item_valid && (state_q == ST_IDLE);
	assign last_p = (p_q == PRESCALER_LAST);

	// The timeout times 1000 as 1024 - 16 - 8.
	assign scaled = ({10'd0, timeout_q} << 10) - ({10'd0, timeout_q} << 4)
		- ({10'd0, timeout_q} << 3);

	// Decode of the divider answer for both kinds of division.
	always_comb begin
		tick_zero = (div_rsp.quotient == '0);
		rem_nz    = (div_rsp.remainder != '0);
		fits      = (div_rsp.quotient < MAX_TICKS) ||
			((div_rsp.quotient == MAX_TICKS) && !rem_nz);
		ticks     = div_rsp.quotient[6:0] + {6'd0, rem_nz};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = (timeout_q == '0) ? ST_FINISH : ST_TICK;
			end
			ST_TICK: begin
				state_d = ST_TICK_WAIT;
			end
			ST_TICK_WAIT: begin
				if (div_rsp.done) begin
					if (!tick_zero)  state_d = ST_COUNT;
					else if (last_p) state_d = ST_FINISH;
					else             state_d = ST_TICK;
				end
			end
			ST_COUNT: begin
				state_d = ST_COUNT_WAIT;
			end
			ST_COUNT_WAIT: begin
				if (div_rsp.done) begin
					if (fits || last_p) state_d = ST_FINISH;
					else                state_d = ST_TICK;
				end
			end
			ST_FINISH: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: divider requests and handshake flags.
	always_comb begin
		busy                 = (state_q != ST_IDLE);
		res_valid            = (state_q == ST_FINISH);
		div_req.start        = 1'b0;
		div_req.dividend     = TICK_BASE_US << p_q;
		div_req.divisor      = DIVISOR_W'(clk_hz);
		case (state_q)
			ST_TICK: begin
				div_req.start = 1'b1;
			end
			ST_COUNT: begin
				div_req.start    = 1'b1;
				div_req.dividend = scaled_q;
				div_req.divisor  = tick_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Working registers and the result being built.
	always_ff @(posedge clk) begin
		if (accept) begin
			timeout_q <= period_ms;
		end
		case (state_q)
			ST_SCALE: begin
				scaled_q           <= scaled;
				p_q                <= 3'd0;
				res_q.status       <= STATUS_PARAM_ERR;
				res_q.prescaler    <= 3'd0;
				res_q.reload_count <= 7'd0;
			end
			ST_TICK_WAIT: begin
				if (div_rsp.done) begin
					tick_q <= div_rsp.quotient[DIVISOR_W-1:0];
					if (tick_zero && !last_p) p_q <= p_q + 3'd1;
				end
			end
			ST_COUNT_WAIT: begin
				if (div_rsp.done) begin
					if (fits) begin
						res_q.status       <= STATUS_OK;
						res_q.prescaler    <= p_q;
						res_q.reload_count <= ((RELOAD_BASE + ticks) > RELOAD_MAX) ?
							RELOAD_MAX : (RELOAD_BASE + ticks);
					end else if (!last_p) begin
						p_q <= p_q + 3'd1;
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

// File: rtl/core/wtpc_checker.sv
`default_nettype none

module wtpc_checker
	import wtpc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        timeout_valid,
	input wire logic        timeout_stall,
	input wire logic        result_valid,
	input wire logic        result_stall,
	input wire logic        status,
	input wire logic [2:0]  prescaler,
	input wire logic [6:0]  reload_count
);

	// Once a timeout is taken, the input is held off while it is worked on.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		timeout_valid && !timeout_stall |=> timeout_stall)
		else $error("input not stalled after a transfer");

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its value.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable({status, prescaler, reload_count}))
		else $error("result changed while stalled");

	// An error result carries zeros.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STATUS_PARAM_ERR) |->
			(prescaler == 3'd0) && (reload_count == 7'd0))
		else $error("error result with non-zero fields");

	// A good result has a reload count of at least 64.
	a_ok_reload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == STATUS_OK) |-> reload_count[6])
		else $error("reload count below 64 on good result");

endmodule

bind watchdog_timeout_to_prescaler_count wtpc_checker u_wtpc_checker (.*);

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wtpc_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 4000000;
	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned SETTLE       = 800;
	localparam int unsigned PHASES       = 12;
	localparam int unsigned PHASE_ITEMS  = 63;

	// Expected watchdog settings, oldest first, predicted from each accepted timeout.
	class watchdog_scoreboard;
		result_t     expected_q[$];
		logic [31:0] clock_hz;
		int unsigned mismatches;

		function new();
			clock_hz   = CLK_DEFAULT_HZ;
			mismatches = 0;
		endfunction

		// Work out the prescaler and reload count for an accepted timeout.
		function void note_timeout(logic [31:0] timeout);
			result_t         r;
			longint unsigned hz;
			longint unsigned tick;
			longint unsigned ticks;
			longint unsigned tms;
			int              p;
			bit              found;
			r.status       = STATUS_PARAM_ERR;
			r.prescaler    = 3'd0;
			r.reload_count = 7'd0;
			found = 1'b0;
			hz    = (clock_hz == 32'd0) ? 64'(CLK_DEFAULT_HZ) : 64'(clock_hz);
			tms   = 64'(timeout);
			if (tms != 0) begin
				for (p = 0; p <= int'(PRESCALER_LAST) && !found; p++) begin
					tick = (64'(TICK_BASE_US) << p) / hz;
					if (tick != 0) begin
						ticks = (tms * 1000 + tick - 1) / tick;
						if (ticks >= 1 && ticks <= 64'(MAX_TICKS)) begin
							found          = 1'b1;
							r.status       = STATUS_OK;
							r.prescaler    = p[2:0];
							r.reload_count = (64'(RELOAD_BASE) + ticks > 64'(RELOAD_MAX)) ?
								RELOAD_MAX : 7'(64'(RELOAD_BASE) + ticks);
						end
					end
				end
			end
			expected_q.push_back(r);
		endfunction

		// Compare a delivered result with the oldest expectation.
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %b/%0d/%0d", $time,
					got.status, got.prescaler, got.reload_count);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status) begin
				$display("%0t: status mismatch, expected %0d, got %0d", $time,
					want.status, got.status);
				mismatches++;
			end
			if (got.prescaler !== want.prescaler) begin
				$display("%0t: prescaler mismatch, expected %0d, got %0d", $time,
					want.prescaler, got.prescaler);
				mismatches++;
			end
			if (got.reload_count !== want.reload_count) begin
				$display("%0t: reload_count mismatch, expected %0d, got %0d", $time,
					want.reload_count, got.reload_count);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        timeout_valid = 1'b0;
	logic        timeout_stall;
	logic [31:0] period_ms     = 32'd0;
	logic        result_valid;
	logic        result_stall  = 1'b0;
	logic        status;
	logic [2:0]  prescaler;
	logic [6:0]  reload_count;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [31:0] bus_clock_hz  = 32'd0;

	watchdog_scoreboard sb = new();

	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	logic        hold_req      = 1'b0;
	int unsigned cycle_count   = 0;
	logic [31:0] current_clock = CLK_DEFAULT_HZ;

	watchdog_timeout_to_prescaler_count uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.timeout_valid(timeout_valid),
		.timeout_stall(timeout_stall),
		.period_ms    (period_ms),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.prescaler    (prescaler),
		.reload_count (reload_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.bus_clock_hz (bus_clock_hz)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Watch every transfer on the three channels at the clock edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.clock_hz = bus_clock_hz;
			if (timeout_valid && !timeout_stall)
				sb.note_timeout(period_ms);
			if (result_valid && !result_stall)
				sb.check_result('{status, prescaler, reload_count});
		end
	end

	// Receiver: random stalls, or one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req     <= 1'b0;
				result_stall <= 1'b0;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// Give up if the run takes far longer than any correct block would.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one timeout and hold it until the transfer takes place.
	task automatic send_timeout(input logic [31:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			timeout_valid <= 1'b0;
			@(posedge clk);
		end
		timeout_valid <= 1'b1;
		period_ms     <= value;
		do
			@(posedge clk);
		while (timeout_stall);
	endtask

	// Let every expected result arrive, then a few more cycles of quiet.
	task automatic drain();
		timeout_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_bus_clock(input logic [31:0] hz);
		cfg_valid    <= 1'b1;
		bus_clock_hz <= hz;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid     <= 1'b0;
		current_clock = hz;
	endtask

	// Pick a timeout that lands on a chosen prescaler, near a fit boundary, or anywhere.
	function automatic logic [31:0] pick_timeout(logic [31:0] hz_reg);
		longint unsigned hz;
		longint unsigned tick;
		longint unsigned max_fit;
		int unsigned     r;
		int unsigned     p;
		hz = (hz_reg == 32'd0) ? 64'(CLK_DEFAULT_HZ) : 64'(hz_reg);
		r  = $urandom_range(99);
		p  = $urandom_range(7);
		tick    = (64'(TICK_BASE_US) << p) / hz;
		max_fit = tick * 64 / 1000;
		if (max_fit > 64'hFFFF_FFFE)
			max_fit = 64'hFFFF_FFFE;
		if (r < 10 || max_fit == 0)
			return $urandom();
		if (r < 20)
			return 32'(max_fit) + 32'($urandom_range(1));
		return $urandom_range(32'(max_fit), 1);
	endfunction

	initial begin
		int unsigned ph;
		int unsigned i;
		logic [31:0] hz;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset clock of 64 MHz: zero, short timeouts that round
		// up, timeouts too long for the last prescaler, and the all-ones timeout.
		send_timeout(32'd0);
		send_timeout(32'd1);
		send_timeout(32'd64);
		send_timeout(32'd65);
		send_timeout(32'd4096);
		send_timeout(32'd4097);
		send_timeout(32'd524288);
		send_timeout(32'd524289);
		send_timeout(32'hFFFF_FFFF);
		send_timeout(32'h5555_5555);
		send_timeout(32'hAAAA_AAAA);
		drain();

		// A zero clock register stands for the default clock.
		write_bus_clock(32'd0);
		send_timeout(32'd4096);
		send_timeout(32'd0);
		drain();

		// A very fast clock makes the first tick zero, so prescaler 0 is skipped.
		write_bus_clock(32'hFFFF_FFFF);
		send_timeout(32'd1);
		send_timeout(32'd3);
		send_timeout(32'hFFFF_FFFF);
		drain();

		// The slowest clock: the limit of the first prescaler and the all-ones timeout.
		write_bus_clock(32'd1);
		send_timeout(32'hFFFF_FFFF);
		send_timeout(32'd262144000);
		send_timeout(32'd262144001);
		send_timeout(32'd1);
		drain();

		// Random phases, each with its own clock and its own idling pattern.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0:       hz = 32'd0;
				1:       hz = 32'd1;
				2:       hz = 32'hFFFF_FFFF;
				3:       hz = 32'd4096000000;
				4:       hz = 32'd4096000001;
				5:       hz = 32'd32768;
				6:       hz = 32'd16000000;
				7:       hz = 32'd170000000;
				default: hz = $urandom();
			endcase
			write_bus_clock(hz);
			case (ph % 4)
				0:       begin send_idle_pct = 0;  stall_pct = 0;  end
				1:       begin send_idle_pct = 66; stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  stall_pct = 66; end
				default: begin send_idle_pct = 12; stall_pct = 12; end
			endcase
			// Hold the receiver off while items keep coming, so the block backs up.
			if (ph == 4)
				hold_req <= 1'b1;
			for (i = 0; i < PHASE_ITEMS; i++)
				send_timeout(pick_timeout(current_clock));
			drain();
		end

		// Catch any stray result after the last expected one.
		timeout_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
